>>> rtl/mexp_pkg.sv
// ============================================================================
// Modular exponentiation package
// Word width, shared types and the modular add and reduce steps used by the
// exponentiation core and its bit-serial multiplier.
// ============================================================================
package mexp_pkg;

   // Width of the arithmetic; only the low WORD_BITS bits of each field count.
   localparam int WORD_BITS  = 64;
   // Width of the request and response fields at the ports.
   localparam int FIELD_BITS = 64;
   // Step counter: counts WORD_BITS-1 down to zero.
   localparam int CNT_BITS   = $clog2(WORD_BITS);

   typedef logic [WORD_BITS-1:0] word_type;
   typedef logic [CNT_BITS-1:0]  cnt_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_REDUCE,
      ST_MUL_LOAD,
      ST_MUL_RUN,
      ST_FINISH
   } state_type;

   // (x + y) mod m for x, y < m, with the carry kept as a 65th bit.
   function automatic word_type add_mod(word_type x, word_type y, word_type m);
      logic [WORD_BITS:0] sum;
      logic [WORD_BITS:0] diff;
      sum  = {1'b0, x} + {1'b0, y};
      diff = sum - {1'b0, m};
      if (sum >= {1'b0, m}) begin
         return diff[WORD_BITS-1:0];
      end else begin
         return sum[WORD_BITS-1:0];
      end
   endfunction

   // One restoring division step: shift the next dividend bit into r (r < m).
   function automatic word_type red_step(word_type r, logic b, word_type m);
      logic [WORD_BITS:0] t;
      logic [WORD_BITS:0] diff;
      t    = {r, b};
      diff = t - {1'b0, m};
      if (t >= {1'b0, m}) begin
         return diff[WORD_BITS-1:0];
      end else begin
         return t[WORD_BITS-1:0];
      end
   endfunction

   // x mod m for x < 2m.
   function automatic word_type reduce_once(word_type x, word_type m);
      if (x >= m) begin
         return x - m;
      end else begin
         return x;
      end
   endfunction

endpackage

>>> rtl/mexp_mod_mul.sv
// ============================================================================
// Bit-serial modular multiplier
// Shift-and-add product modulo m, taking one multiplier bit per cycle.
// ============================================================================
module mexp_mod_mul import mexp_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  logic     start,
   input  word_type multiplicand,
   input  word_type multiplier,
   input  word_type modulus,
   output word_type product,
   output logic     done
);

   logic     busy_ff, busy_in;
   logic     done_ff, done_in;
   cnt_type  cnt_ff, cnt_in;
   word_type addend_ff, addend_in;
   word_type bits_ff, bits_in;
   word_type sum_ff, sum_in;

   always_comb begin
      busy_in   = busy_ff;
      cnt_in    = cnt_ff;
      addend_in = addend_ff;
      bits_in   = bits_ff;
      sum_in    = sum_ff;
      done_in   = 1'b0;
      if (start) begin
         busy_in   = 1'b1;
         cnt_in    = CNT_BITS'(WORD_BITS - 1);
         addend_in = reduce_once(multiplicand, modulus);
         bits_in   = multiplier;
         sum_in    = '0;
      end else if (busy_ff) begin
         if (bits_ff[0]) begin
            sum_in = add_mod(sum_ff, addend_ff, modulus);
         end
         addend_in = add_mod(addend_ff, addend_ff, modulus);
         bits_in   = bits_ff >> 1;
         cnt_in    = cnt_ff - 1'b1;
         if (cnt_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      cnt_ff    <= cnt_in;
      addend_ff <= addend_in;
      bits_ff   <= bits_in;
      sum_ff    <= sum_in;
   end

   assign product = sum_ff;
   assign done    = done_ff;

endmodule

>>> rtl/modular_exponentiation_core.sv
// Throughput: one request at a time, as requests are taken only in the idle state;
// the next is taken the cycle after the previous result enters the response register.
// Reset: synchronous, active high; clears the controller and the response valid.
// ============================================================================
// Modular exponentiation core
// Computes base^exponent mod modulus by a bit-serial base reduction followed
// by right-to-left square-and-multiply on two bit-serial modular multipliers.
// ============================================================================
module modular_exponentiation_core import mexp_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [FIELD_BITS-1:0] req_base,
   input  logic [FIELD_BITS-1:0] req_exponent,
   input  logic [FIELD_BITS-1:0] req_modulus,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [FIELD_BITS-1:0] rsp_power_result,
   output logic                  rsp_zero_modulus
);

   // Controller state.
   state_type state_ff, state_in;

   // Working registers. The base is consumed most significant bit first by the
   // reduction, and the exponent least significant bit first by the power loop.
   word_type m_ff, m_in;
   word_type exp_ff, exp_in;
   word_type base_ff, base_in;
   word_type rem_ff, rem_in;
   cnt_type  cnt_ff, cnt_in;
   word_type acc_ff, acc_in;
   word_type sq_ff, sq_in;
   logic     zero_ff, zero_in;

   // Response register, which lets a finished result wait for the consumer.
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [FIELD_BITS-1:0] rsp_result_ff, rsp_result_in;
   logic                  rsp_zero_ff, rsp_zero_in;

   // Controls from the output decoder.
   logic mul_start;
   logic out_load;

   // Multiplier results. Both units run in lockstep on the same multiplier
   // bits (the current square), so a single done is used.
   word_type acc_prod;
   word_type sq_prod;
   logic     acc_done;
   logic     sq_done;

   word_type req_modulus_w;
   assign req_modulus_w = req_modulus[WORD_BITS-1:0];

   // The running product: acc times the square, used only when the current
   // exponent bit is set.
   mexp_mod_mul u_acc_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (acc_ff),
      .multiplier   (sq_ff),
      .modulus      (m_ff),
      .product      (acc_prod),
      .done         (acc_done)
   );

   // The square of the square.
   mexp_mod_mul u_sq_mul (
      .clock        (clock),
      .reset        (reset),
      .start        (mul_start),
      .multiplicand (sq_ff),
      .multiplier   (sq_ff),
      .modulus      (m_ff),
      .product      (sq_prod),
      .done         (sq_done)
   );

   // Next-state logic.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_modulus_w == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_REDUCE;
               end
            end
         end
         ST_REDUCE: begin
            if (cnt_ff == '0) begin
               if (exp_ff == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL_LOAD;
               end
            end
         end
         ST_MUL_LOAD: begin
            state_in = ST_MUL_RUN;
         end
         ST_MUL_RUN: begin
            if (sq_done) begin
               if ((exp_ff >> 1) == '0) begin
                  state_in = ST_FINISH;
               end else begin
                  state_in = ST_MUL_LOAD;
               end
            end
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Output decoder.
   always_comb begin
      req_ready = 1'b0;
      mul_start = 1'b0;
      out_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
         end
         ST_MUL_LOAD: begin
            mul_start = 1'b1;
         end
         ST_FINISH: begin
            out_load = !rsp_valid_ff || rsp_ready;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // Datapath. On acceptance the operands are latched and the remainder is
   // cleared; a zero modulus goes straight to the response with a zero
   // result. The reduction then shifts one base bit per cycle into the
   // remainder. Each power step updates the accumulator only when the low
   // exponent bit is set, always replaces the square, and shifts the exponent.
   always_comb begin
      m_in    = m_ff;
      exp_in  = exp_ff;
      base_in = base_ff;
      rem_in  = rem_ff;
      cnt_in  = cnt_ff;
      acc_in  = acc_ff;
      sq_in   = sq_ff;
      zero_in = zero_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               m_in    = req_modulus_w;
               exp_in  = req_exponent[WORD_BITS-1:0];
               base_in = req_base[WORD_BITS-1:0];
               rem_in  = '0;
               cnt_in  = CNT_BITS'(WORD_BITS - 1);
               acc_in  = '0;
               zero_in = (req_modulus_w == '0);
            end
         end
         ST_REDUCE: begin
            rem_in  = red_step(rem_ff, base_ff[WORD_BITS-1], m_ff);
            base_in = base_ff << 1;
            cnt_in  = cnt_ff - 1'b1;
            if (cnt_ff == '0) begin
               // The reduced base becomes the first square; a zero exponent
               // leaves the unreduced one as the result.
               sq_in  = rem_in;
               acc_in = WORD_BITS'(1);
            end
         end
         ST_MUL_RUN: begin
            if (sq_done) begin
               if (exp_ff[0]) begin
                  acc_in = acc_prod;
               end
               sq_in  = sq_prod;
               exp_in = exp_ff >> 1;
            end
         end
         default: begin
            m_in = m_ff;
         end
      endcase
   end

   // The response register is refilled only when it is empty or being taken.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_result_in = rsp_result_ff;
      rsp_zero_in   = rsp_zero_ff;
      if (out_load) begin
         rsp_valid_in  = 1'b1;
         rsp_result_in = FIELD_BITS'(acc_ff);
         rsp_zero_in   = zero_ff;
      end else if (rsp_ready) begin
         rsp_valid_in  = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      m_ff          <= m_in;
      exp_ff        <= exp_in;
      base_ff       <= base_in;
      rem_ff        <= rem_in;
      cnt_ff        <= cnt_in;
      acc_ff        <= acc_in;
      sq_ff         <= sq_in;
      zero_ff       <= zero_in;
      rsp_result_ff <= rsp_result_in;
      rsp_zero_ff   <= rsp_zero_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_power_result = rsp_result_ff;
   assign rsp_zero_modulus = rsp_zero_ff;

   // The two multipliers are started together and must finish together.
   assert property (@(posedge clock) disable iff (reset) acc_done == sq_done)
      else $error("multipliers out of step");

   // While the power loop runs, the square is fully reduced.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_RUN |-> sq_ff < m_ff)
      else $error("square not reduced");

   // The accumulator is reduced, or is still the initial one.
   assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MUL_RUN |-> (acc_ff < m_ff || acc_ff == WORD_BITS'(1)))
      else $error("accumulator not reduced");

   // A zero-modulus response always carries a zero result.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_modulus |-> rsp_power_result == '0)
      else $error("zero modulus with nonzero result");

endmodule
